FILE: src/bfam_pkg.sv
// Package with types, constants and register indexes of the battery frame alarm monitor.
package bfam_pkg;

    localparam logic [10:0] ID_CHARGE = 11'h0AC;
    localparam logic [10:0] ID_INSUL  = 11'h268;
    localparam logic [10:0] ID_CELL   = 11'h269;
    localparam logic [10:0] ID_TEMP   = 11'h373;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_CELL_HIGH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CELL_LOW   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SPREAD_MAX = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_INSUL_MIN  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_LIMIT = 3'd4;

    localparam logic [15:0] CELL_HIGH_RST  = 16'd4300;
    localparam logic [15:0] CELL_LOW_RST   = 16'd3400;
    localparam logic [15:0] SPREAD_MAX_RST = 16'd80;
    localparam logic [15:0] INSUL_MIN_RST  = 16'd8000;
    localparam logic [7:0]  TEMP_LIMIT_RST = 8'd190;

    localparam int ALARM_INSUL  = 0;
    localparam int ALARM_AVG    = 1;
    localparam int ALARM_SPREAD = 2;
    localparam int ALARM_MAX    = 3;
    localparam int ALARM_MIN    = 4;
    localparam int ALARM_TEMP   = 5;

    localparam logic MODE_FRAME   = 1'b0;
    localparam logic MODE_SILENCE = 1'b1;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 120;

    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_CHARGE = 3'd1,
        KIND_INSUL  = 3'd2,
        KIND_CELL   = 3'd3,
        KIND_TEMP   = 3'd4
    } kind_t;

    typedef struct packed {
        logic [15:0] cell_high_mv;
        logic [15:0] cell_low_mv;
        logic [15:0] spread_max_mv;
        logic [15:0] insulation_min_kohm;
        logic [7:0]  temp_limit_raw;
    } cfg_t;

    typedef struct packed {
        logic        mode;
        logic [10:0] frame_id;
        logic [3:0]  frame_len;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [7:0]  byte2;
        logic [7:0]  byte3;
        logic [7:0]  byte4;
        logic [7:0]  byte6;
        logic [7:0]  byte7;
    } frame_t;

    typedef struct packed {
        kind_t        kind;
        logic [7:0]   charge_half_pct;
        logic [12:0]  pack_decivolt;
        logic [15:0]  insulation_kohm;
        logic [15:0]  cell_max_mv;
        logic [15:0]  cell_min_mv;
        logic [16:0]  cell_sum_mv;
        logic [16:0]  cell_spread_mv;
        logic [7:0]   temp_raw;
        logic [5:0]   alarm_flags;
        logic         beep;
    } result_t;

endpackage

FILE: src/bfam_cfg_regs.sv
// Configuration register file with the alarm limits.
module bfam_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [bfam_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bfam_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output bfam_pkg::cfg_t                    cfg
);

    bfam_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cell_high_mv        <= bfam_pkg::CELL_HIGH_RST;
            cfg_reg.cell_low_mv         <= bfam_pkg::CELL_LOW_RST;
            cfg_reg.spread_max_mv       <= bfam_pkg::SPREAD_MAX_RST;
            cfg_reg.insulation_min_kohm <= bfam_pkg::INSUL_MIN_RST;
            cfg_reg.temp_limit_raw      <= bfam_pkg::TEMP_LIMIT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                bfam_pkg::REG_CELL_HIGH:  cfg_reg.cell_high_mv        <= cfg_wdata;
                bfam_pkg::REG_CELL_LOW:   cfg_reg.cell_low_mv         <= cfg_wdata;
                bfam_pkg::REG_SPREAD_MAX: cfg_reg.spread_max_mv       <= cfg_wdata;
                bfam_pkg::REG_INSUL_MIN:  cfg_reg.insulation_min_kohm <= cfg_wdata;
                bfam_pkg::REG_TEMP_LIMIT: cfg_reg.temp_limit_raw      <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: src/bfam_decode.sv
// Frame decoder and limit checks that produce one result and the next beep latch value.
module bfam_decode (
    input  bfam_pkg::frame_t   frame,
    input  bfam_pkg::cfg_t     cfg,
    input  logic               beep_in,
    output bfam_pkg::result_t  result,
    output logic               beep_next
);

    logic [15:0]        cmax;
    logic [15:0]        cmin;
    logic [16:0]        csum;
    logic signed [17:0] diff;
    logic [16:0]        high2;
    logic [16:0]        low2;
    logic               decode_en;

    assign cmax  = {frame.byte0, frame.byte1};
    assign cmin  = {frame.byte2, frame.byte3};
    assign csum  = {1'b0, cmax} + {1'b0, cmin};
    assign diff  = $signed({2'b00, cmax}) - $signed({2'b00, cmin});
    assign high2 = {cfg.cell_high_mv, 1'b0};
    assign low2  = {cfg.cell_low_mv, 1'b0};
    assign decode_en = (frame.mode == bfam_pkg::MODE_FRAME) && (frame.frame_len != 4'd0);

    always_comb begin
        result = '0;
        result.kind = bfam_pkg::KIND_NONE;
        if (decode_en) begin
            unique case (frame.frame_id)
                bfam_pkg::ID_CHARGE: begin
                    result.kind            = bfam_pkg::KIND_CHARGE;
                    result.charge_half_pct = frame.byte4;
                    result.pack_decivolt   = {frame.byte2[4:0], frame.byte3};
                end
                bfam_pkg::ID_INSUL: begin
                    result.kind            = bfam_pkg::KIND_INSUL;
                    result.insulation_kohm = {frame.byte6, frame.byte7};
                    result.alarm_flags[bfam_pkg::ALARM_INSUL] =
                        ({frame.byte6, frame.byte7} <= cfg.insulation_min_kohm);
                end
                bfam_pkg::ID_CELL: begin
                    result.kind           = bfam_pkg::KIND_CELL;
                    result.cell_max_mv    = cmax;
                    result.cell_min_mv    = cmin;
                    result.cell_sum_mv    = csum;
                    result.cell_spread_mv = diff[16:0];
                    result.alarm_flags[bfam_pkg::ALARM_AVG] = (csum >= high2) || (csum <= low2);
                    result.alarm_flags[bfam_pkg::ALARM_SPREAD] =
                        (diff >= $signed({2'b00, cfg.spread_max_mv}));
                    result.alarm_flags[bfam_pkg::ALARM_MAX] =
                        (cmax >= cfg.cell_high_mv) || (cmax <= cfg.cell_low_mv);
                    result.alarm_flags[bfam_pkg::ALARM_MIN] =
                        (cmin >= cfg.cell_high_mv) || (cmin <= cfg.cell_low_mv);
                end
                bfam_pkg::ID_TEMP: begin
                    result.kind     = bfam_pkg::KIND_TEMP;
                    result.temp_raw = frame.byte2;
                    result.alarm_flags[bfam_pkg::ALARM_TEMP] =
                        (frame.byte2 >= cfg.temp_limit_raw);
                end
                default: ;
            endcase
        end
        if (frame.mode == bfam_pkg::MODE_SILENCE) begin
            beep_next = 1'b0;
        end else begin
            beep_next = beep_in || (result.alarm_flags != 6'd0);
        end
        result.beep = beep_next;
    end

endmodule

FILE: src/battery_frame_alarm_monitor.sv
// Top level of the battery frame alarm monitor with input and result registers.
// The block takes one request per clock cycle while the sink keeps up and returns exactly one
// result per request: the request is captured in an input register, decoded and checked against
// the limits in one step of logic, and the result is held in an output register, so that a new
// request is still accepted while a finished result waits for the sink, if the input register
// is empty. A silence request clears the beep latch; any alarm in a decoded frame sets it. The user
// must write limits through the configuration port only while no request is in flight (unenforced).
module battery_frame_alarm_monitor (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [bfam_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bfam_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // frame_id, frame_len, byte0 .. byte7, one zero pad bit
    input  logic [bfam_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // mode
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // charge_half_pct, pack_decivolt, insulation_kohm, cell_max_mv, cell_min_mv, cell_sum_mv,
    // cell_spread_mv, temp_raw, alarm_flags, beep, two zero pad bits
    output logic [bfam_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // kind
    output logic [2:0]                        m_axis_tuser
);

    bfam_pkg::cfg_t    cfg;
    bfam_pkg::frame_t  in_reg;
    bfam_pkg::frame_t  in_next;
    bfam_pkg::result_t res_next;
    bfam_pkg::result_t out_reg;
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic              beep_reg;
    logic              beep_next;
    logic              out_load;
    logic              in_load;

    bfam_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bfam_decode u_decode (
        .frame     (in_reg),
        .cfg       (cfg),
        .beep_in   (beep_reg),
        .result    (res_next),
        .beep_next (beep_next)
    );

    assign out_load      = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || out_load;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    always_comb begin
        in_next.mode      = s_axis_tuser;
        in_next.frame_id  = s_axis_tdata[10:0];
        in_next.frame_len = s_axis_tdata[14:11];
        in_next.byte0     = s_axis_tdata[22:15];
        in_next.byte1     = s_axis_tdata[30:23];
        in_next.byte2     = s_axis_tdata[38:31];
        in_next.byte3     = s_axis_tdata[46:39];
        in_next.byte4     = s_axis_tdata[54:47];
        in_next.byte6     = s_axis_tdata[70:63];
        in_next.byte7     = s_axis_tdata[78:71];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            beep_reg      <= 1'b0;
        end else begin
            if (in_load) begin
                in_valid_reg <= 1'b1;
            end else if (out_load) begin
                in_valid_reg <= 1'b0;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
                beep_reg      <= beep_next;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_reg <= in_next;
        end
        if (out_load) begin
            out_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tdata  = {2'b00,
                            out_reg.beep,
                            out_reg.alarm_flags,
                            out_reg.temp_raw,
                            out_reg.cell_spread_mv,
                            out_reg.cell_sum_mv,
                            out_reg.cell_min_mv,
                            out_reg.cell_max_mv,
                            out_reg.insulation_kohm,
                            out_reg.pack_decivolt,
                            out_reg.charge_half_pct};

    a_none_no_alarm: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_reg.kind == bfam_pkg::KIND_NONE) |-> out_reg.alarm_flags == 6'd0)
        else $error("Result without a decoded frame carries alarm flags.");

    a_alarm_beeps: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_reg.alarm_flags != 6'd0) |-> out_reg.beep)
        else $error("Alarm in a result without the beep latch set.");

    a_silence_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && (in_reg.mode == bfam_pkg::MODE_SILENCE) |=> !beep_reg)
        else $error("Silence request did not clear the beep latch.");

    a_beep_rise_on_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(beep_reg) |-> $past(out_load))
        else $error("Beep latch set without a result being loaded.");

    a_result_beep_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> out_reg.beep == beep_reg)
        else $error("Result beep bit differs from the latch.");

    a_cell_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_reg.kind == bfam_pkg::KIND_CELL) |->
            out_reg.cell_sum_mv == ({1'b0, out_reg.cell_max_mv} + {1'b0, out_reg.cell_min_mv}))
        else $error("Cell sum does not match its operands.");

endmodule
